// File: rtl/core/b32c_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b32c_pkg;

  localparam int AccWidth = 12;
  localparam int CntWidth = 4;
  localparam int DataWidth = 8;
  localparam int DigitWidth = 5;
  localparam int MaxResults = 3;

  localparam logic [CntWidth-1:0] EncBits = 4'd8;
  localparam logic [CntWidth-1:0] DecBits = 4'd5;
  localparam logic [CntWidth-1:0] DigitBits = 4'd5;
  localparam logic [CntWidth-1:0] TwoDigitBits = 4'd10;
  localparam logic [CntWidth-1:0] ByteBits = 4'd8;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  localparam logic [DigitWidth:0] DecBad = 6'h20;

  typedef struct packed {
    logic [AccWidth-1:0] acc;
    logic [CntWidth-1:0] cnt;
    logic                err;
  } state_t;

  typedef struct packed {
    logic [DataWidth-1:0] value;
    logic                 has_data;
    logic                 last;
    logic                 error;
  } res_t;

  // digit to alphabet character, no I, O, Q or V
  function automatic logic [DataWidth-1:0] enc_char(input logic [DigitWidth-1:0] d);
    logic [DataWidth-1:0] c;
    case (d)
      5'd0:  c = "0";
      5'd1:  c = "1";
      5'd2:  c = "2";
      5'd3:  c = "3";
      5'd4:  c = "4";
      5'd5:  c = "5";
      5'd6:  c = "6";
      5'd7:  c = "7";
      5'd8:  c = "8";
      5'd9:  c = "9";
      5'd10: c = "A";
      5'd11: c = "B";
      5'd12: c = "C";
      5'd13: c = "D";
      5'd14: c = "E";
      5'd15: c = "F";
      5'd16: c = "G";
      5'd17: c = "H";
      5'd18: c = "J";
      5'd19: c = "K";
      5'd20: c = "L";
      5'd21: c = "M";
      5'd22: c = "N";
      5'd23: c = "P";
      5'd24: c = "R";
      5'd25: c = "S";
      5'd26: c = "T";
      5'd27: c = "U";
      5'd28: c = "W";
      5'd29: c = "X";
      5'd30: c = "Y";
      default: c = "Z";
    endcase
    return c;
  endfunction

  // character to digit, top bit flags an invalid character
  function automatic logic [DigitWidth:0] dec_char(input logic [DataWidth-1:0] v);
    logic [DataWidth-1:0] c;
    logic [DigitWidth:0]  r;
    c = v;
    if (v >= "a" && v <= "z") begin
      c = v - 8'd32;
    end
    r = DecBad;
    if (c >= "0" && c <= "9") begin
      r = {1'b0, 5'(c - "0")};
    end else begin
      case (c)
        "A": r = 6'd10;
        "B": r = 6'd11;
        "C": r = 6'd12;
        "D": r = 6'd13;
        "E": r = 6'd14;
        "F": r = 6'd15;
        "G": r = 6'd16;
        "H": r = 6'd17;
        "I": r = 6'd1;
        "J": r = 6'd18;
        "K": r = 6'd19;
        "L": r = 6'd20;
        "M": r = 6'd21;
        "N": r = 6'd22;
        "O": r = 6'd0;
        "P": r = 6'd23;
        "R": r = 6'd24;
        "S": r = 6'd25;
        "T": r = 6'd26;
        "U": r = 6'd27;
        "W": r = 6'd28;
        "X": r = 6'd29;
        "Y": r = 6'd30;
        "Z": r = 6'd31;
        default: r = DecBad;
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/b32c_step.sv
`timescale 1ns / 1ps
`default_nettype none

module b32c_step (
  input  wire logic                         mode_i,
  input  wire b32c_pkg::state_t             st_i,
  input  wire logic [b32c_pkg::DataWidth-1:0] value_i,
  input  wire logic                         last_i,
  output b32c_pkg::state_t                  st_o,
  output b32c_pkg::res_t [2:0]              res_o,
  output logic [1:0]                        n_o
);

  logic [b32c_pkg::AccWidth-1:0]   sum;
  logic [b32c_pkg::CntWidth-1:0]   cnt_t;
  logic [b32c_pkg::DigitWidth:0]   dv;
  logic                            err_new;

  always_comb begin
    st_o   = st_i;
    res_o  = '0;
    n_o    = 2'd0;
    sum    = '0;
    cnt_t  = '0;
    dv     = b32c_pkg::dec_char(value_i);
    err_new = st_i.err;

    if (mode_i == b32c_pkg::ModeEncode) begin
      if (!st_i.err) begin
        sum   = st_i.acc | ({4'b0, value_i} << st_i.cnt[2:0]);
        cnt_t = st_i.cnt + b32c_pkg::EncBits;
        res_o[0].value    = b32c_pkg::enc_char(sum[4:0]);
        res_o[0].has_data = 1'b1;
        if (cnt_t >= b32c_pkg::TwoDigitBits) begin
          res_o[1].value    = b32c_pkg::enc_char(sum[9:5]);
          res_o[1].has_data = 1'b1;
          st_o.acc = {10'b0, sum[11:10]};
          st_o.cnt = cnt_t - b32c_pkg::TwoDigitBits;
          n_o      = 2'd2;
        end else begin
          st_o.acc = {5'b0, sum[11:5]};
          st_o.cnt = cnt_t - b32c_pkg::DigitBits;
          n_o      = 2'd1;
        end
        // flush leftover bits as one zero-padded character
        if (last_i && st_o.cnt != '0) begin
          if (n_o == 2'd2) begin
            res_o[2].value    = b32c_pkg::enc_char(st_o.acc[4:0]);
            res_o[2].has_data = 1'b1;
            n_o               = 2'd3;
          end else begin
            res_o[1].value    = b32c_pkg::enc_char(st_o.acc[4:0]);
            res_o[1].has_data = 1'b1;
            n_o               = 2'd2;
          end
        end
      end
    end else begin
      err_new  = st_i.err | dv[b32c_pkg::DigitWidth];
      st_o.err = err_new;
      if (!err_new) begin
        sum   = st_i.acc | ({7'b0, dv[4:0]} << st_i.cnt[2:0]);
        cnt_t = st_i.cnt + b32c_pkg::DecBits;
        if (cnt_t >= b32c_pkg::ByteBits) begin
          res_o[0].value    = sum[7:0];
          res_o[0].has_data = 1'b1;
          st_o.acc = {8'b0, sum[11:8]};
          st_o.cnt = cnt_t - b32c_pkg::ByteBits;
          n_o      = 2'd1;
        end else begin
          st_o.acc = sum;
          st_o.cnt = cnt_t;
        end
      end
    end

    res_o[0].error = err_new;
    res_o[1].error = err_new;
    res_o[2].error = err_new;

    if (last_i) begin
      case (n_o)
        2'd0: begin
          res_o[0].last = 1'b1;
          n_o           = 2'd1;
        end
        2'd1: res_o[0].last = 1'b1;
        2'd2: res_o[1].last = 1'b1;
        default: res_o[2].last = 1'b1;
      endcase
      st_o = '0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/base32_lsb_codec.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming Base32 codec, least significant bit first, alphabet without I, O, Q and V.
// Register mode at address 0 (0 encode, 1 decode); writing it clears the block state.
// A request is taken and its results (one to three when encoding, zero or one when
// decoding, plus an end marker on a last request that makes no data) appear from the
// next cycle on, one per cycle while the output side takes them, from a three-entry
// result buffer. The next request is taken in the cycle the last buffered result
// leaves, so encoding is paced by the characters it makes (one or two per byte, three
// with a flush, eight characters for five bytes on average) and decoding takes one
// character per cycle, as long as the output side keeps taking results.
module base32_lsb_codec (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_value_i,
  input  wire logic        in_last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_value_o,
  output logic             out_has_data_o,
  output logic             out_last_o,
  output logic             out_error_o
);

  logic                        mode_q;
  b32c_pkg::state_t            st_q, st_d;
  b32c_pkg::res_t [2:0]        ent_q, ent_d, res;
  logic [1:0]                  rem_q, rem_d, n;
  logic                        cfg_wr, accept, pop;

  b32c_step u_step (
    .mode_i  (mode_q),
    .st_i    (st_q),
    .value_i (in_value_i),
    .last_i  (in_last_i),
    .st_o    (st_d),
    .res_o   (res),
    .n_o     (n)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'b0 : {31'b0, mode_q};

  assign out_valid_o = (rem_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign in_ready_o  = (rem_q == 2'd0) || ((rem_q == 2'd1) && out_ready_i);
  assign accept      = in_valid_i && in_ready_o;

  assign out_value_o    = ent_q[0].value;
  assign out_has_data_o = ent_q[0].has_data;
  assign out_last_o     = ent_q[0].last;
  assign out_error_o    = ent_q[0].error;

  always_comb begin
    ent_d = ent_q;
    rem_d = rem_q;
    if (accept) begin
      ent_d = res;
      rem_d = n;
    end else if (pop) begin
      ent_d[0] = ent_q[1];
      ent_d[1] = ent_q[2];
      rem_d    = rem_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= b32c_pkg::ModeEncode;
      st_q   <= '0;
      rem_q  <= 2'd0;
    end else begin
      rem_q <= rem_d;
      if (cfg_wr) begin
        mode_q <= pwdata[0];
        st_q   <= '0;
      end else if (accept) begin
        st_q <= st_d;
      end
    end
  end

  // result buffer payload
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

`default_nettype wire

// File: test/tb_base32_lsb_codec.sv
`timescale 1ns / 1ps

module tb_base32_lsb_codec;

  localparam logic [2:0] ModeRegAddr = 3'd0;
  localparam logic [2:0] UnusedRegAddr = 3'd4;
  localparam logic [255:0] B32Alphabet = "0123456789ABCDEFGHJKLMNPRSTUWXYZ";
  localparam int unsigned CycleLimit = 200000;
  localparam int DrainCycles = 12;
  localparam int MaxPrinted = 20;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } codec_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_value_i = '0;
  logic        in_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_value_o;
  logic        out_has_data_o;
  logic        out_last_o;
  logic        out_error_o;

  base32_lsb_codec u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_value_i     (in_value_i),
    .in_last_i      (in_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_value_o    (out_value_o),
    .out_has_data_o (out_has_data_o),
    .out_last_o     (out_last_o),
    .out_error_o    (out_error_o)
  );

  always #2 clk_i = ~clk_i;

  codec_req_t      pending_reqs[$];
  b32c_pkg::res_t  expected_results[$];
  logic            cur_mode = b32c_pkg::ModeEncode;
  logic [11:0]     pend_bits = '0;
  logic [3:0]      pend_count = '0;
  logic            block_err = 1'b0;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     cycle_count = 0;
  int              errors = 0;
  int              n_reqs = 0;
  int              n_results = 0;
  int              n_mode_writes = 0;
  bit              req_taken = 1'b0;
  b32c_pkg::res_t  want;

  function automatic logic [7:0] b32_char(input logic [4:0] d);
    return B32Alphabet[8*(31-d) +: 8];
  endfunction

  // folds case and maps the O and I aliases
  function automatic logic char_to_digit(input logic [7:0] ch, output logic [4:0] d);
    logic [7:0] up;
    logic       ok;
    int         k;
    up = ch;
    ok = 1'b0;
    d = '0;
    if (ch >= "a" && ch <= "z") begin
      up = ch - 8'd32;
    end
    if (up == "O") begin
      ok = 1'b1;
    end else if (up == "I") begin
      d = 5'd1;
      ok = 1'b1;
    end else begin
      for (k = 0; k < 32; k++) begin
        if (b32_char(5'(k)) == up) begin
          d = 5'(k);
          ok = 1'b1;
        end
      end
    end
    return ok;
  endfunction

  function automatic b32c_pkg::res_t make_res(input logic [7:0] v, input logic has_data);
    b32c_pkg::res_t r;
    r.value = v;
    r.has_data = has_data;
    r.last = 1'b0;
    r.error = block_err;
    return r;
  endfunction

  function automatic void predict_codec_results(input logic [7:0] v, input logic last);
    b32c_pkg::res_t outs[3];
    int             n;
    int             k;
    logic [19:0]    wide;
    logic [4:0]     d;
    n = 0;
    if (cur_mode == b32c_pkg::ModeEncode) begin
      if (!block_err) begin
        wide = {8'b0, pend_bits} | ({12'b0, v} << pend_count[2:0]);
        pend_bits = wide[11:0];
        pend_count = pend_count + 4'd8;
        while (pend_count >= 4'd5 && n < 2) begin
          outs[n] = make_res(b32_char(pend_bits[4:0]), 1'b1);
          n++;
          pend_bits = pend_bits >> 5;
          pend_count = pend_count - 4'd5;
        end
        if (last && pend_count > 0) begin
          outs[n] = make_res(b32_char(pend_bits[4:0]), 1'b1);
          n++;
        end
      end
    end else begin
      if (!char_to_digit(v, d)) begin
        block_err = 1'b1;
      end
      if (!block_err) begin
        wide = {8'b0, pend_bits} | ({15'b0, d} << pend_count[2:0]);
        pend_bits = wide[11:0];
        pend_count = pend_count + 4'd5;
        if (pend_count >= 4'd8) begin
          outs[n] = make_res(pend_bits[7:0], 1'b1);
          n++;
          pend_bits = pend_bits >> 8;
          pend_count = pend_count - 4'd8;
        end
      end
    end
    if (last) begin
      if (n == 0) begin
        outs[n] = make_res(8'h00, 1'b0);
        n++;
      end
      outs[n-1].last = 1'b1;
      pend_bits = '0;
      pend_count = '0;
      block_err = 1'b0;
    end
    for (k = 0; k < n; k++) begin
      expected_results.push_back(outs[k]);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MaxPrinted) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_taken)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_value_i <= pending_reqs[0].value;
        in_last_i <= pending_reqs[0].last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    req_taken = 1'b0;
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // acceptance and result checking
  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_codec_results(in_value_i, in_last_i);
      void'(pending_reqs.pop_front());
      req_taken = 1'b1;
      n_reqs++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %02h", out_value_o));
      end else begin
        want = expected_results.pop_front();
        if (out_value_o !== want.value) begin
          report_mismatch($sformatf("value %02h, want %02h", out_value_o, want.value));
        end
        if (out_has_data_o !== want.has_data) begin
          report_mismatch($sformatf("has_data %b, want %b", out_has_data_o, want.has_data));
        end
        if (out_last_o !== want.last) begin
          report_mismatch($sformatf("last %b, want %b", out_last_o, want.last));
        end
        if (out_error_o !== want.error) begin
          report_mismatch($sformatf("error %b, want %b", out_error_o, want.error));
        end
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("base32_lsb_codec test failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ModeRegAddr) begin
      cur_mode = data[0];
      pend_bits = '0;
      pend_count = '0;
      block_err = 1'b0;
      n_mode_writes++;
    end
  endtask

  task automatic add_req(input logic [7:0] v, input logic last);
    codec_req_t r;
    r.value = v;
    r.last = last;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // mostly whole blocks, some stray requests, last block may be cut short
  task automatic add_blocks(input logic decode, input int target);
    int         added;
    int         len;
    int         k;
    int         p;
    logic [7:0] ch;
    added = 0;
    while (added < target) begin
      if ($urandom_range(99) < 6) begin
        add_req(8'($urandom_range(255)), 1'($urandom_range(1)));
        added++;
      end else begin
        len = decode ? $urandom_range(10, 1) : $urandom_range(8, 1);
        for (k = 0; k < len && added < target; k++) begin
          if (!decode) begin
            ch = 8'($urandom_range(255));
          end else begin
            p = $urandom_range(99);
            if (p < 4) begin
              ch = 8'($urandom_range(255));
            end else if (p < 12) begin
              case ($urandom_range(3))
                0: ch = "O";
                1: ch = "o";
                2: ch = "I";
                default: ch = "i";
              endcase
            end else begin
              ch = b32_char(5'($urandom_range(31)));
              if (ch >= "A" && $urandom_range(1) == 1) begin
                ch = ch + 8'd32;
              end
            end
          end
          add_req(ch, k == len - 1);
          added++;
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // encode, no idling
    write_reg(ModeRegAddr, 32'h0);
    add_req(8'h00, 1'b1);
    add_req(8'hFF, 1'b1);
    add_req(8'h12, 1'b0);
    add_req(8'h34, 1'b1);
    add_req(8'hA5, 1'b0);
    add_req(8'h5A, 1'b0);
    add_req(8'h00, 1'b0);
    add_req(8'hFF, 1'b0);
    add_req(8'h3C, 1'b1);
    add_blocks(b32c_pkg::ModeEncode, 15);
    wait_drained();
    add_blocks(b32c_pkg::ModeEncode, 15);
    wait_drained();

    // decode, sender idles
    write_reg(ModeRegAddr, 32'hFFFF_FFFF);
    send_idle_pct = 58;
    recv_stall_pct = 0;
    add_req("Z", 1'b0);
    add_req("z", 1'b1);
    add_req("o", 1'b0);
    add_req("I", 1'b0);
    add_req("i", 1'b1);
    add_req("A", 1'b0);
    add_req("Q", 1'b0);
    add_req("5", 1'b0);
    add_req("v", 1'b1);
    add_req(8'h00, 1'b1);
    add_req(8'hFF, 1'b0);
    add_req("9", 1'b1);
    add_req(":", 1'b0);
    add_req("@", 1'b1);
    add_req("[", 1'b0);
    add_req("{", 1'b1);
    add_blocks(b32c_pkg::ModeDecode, 35);
    wait_drained();

    // write to an unused address must leave the block untouched
    write_reg(UnusedRegAddr, 32'h1);
    send_idle_pct = 0;
    recv_stall_pct = 58;
    add_blocks(b32c_pkg::ModeDecode, 35);
    wait_drained();

    write_reg(ModeRegAddr, 32'hFFFF_FFFE);
    send_idle_pct = 32;
    recv_stall_pct = 32;
    add_blocks(b32c_pkg::ModeEncode, 25);
    wait_drained();

    write_reg(ModeRegAddr, 32'h1);
    add_blocks(b32c_pkg::ModeDecode, 20);
    wait_drained();

    $display("checked %0d results from %0d requests across %0d mode writes",
             n_results, n_reqs, n_mode_writes);
    $display("both modes, flushes, aliases, bad characters, all idle and stall mixes");
    if (errors == 0) begin
      $display("base32_lsb_codec test passed");
    end else begin
      $display("base32_lsb_codec test failed");
    end
    $finish;
  end

endmodule
